[hdl/edmt_pkg.sv]
// Package for the egg drop minimum trials unit.
// Holds the fixed payload widths and the sequencer state type; no dependencies.
package edmt_pkg;

   localparam int EGGS_W   = 5;
   localparam int FLOORS_W = 11;
   localparam int TRIALS_W = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_LAST,
      ST_DONE
   } state_type;

endpackage

[hdl/egg_drop_min_trials_unit.sv]
// Egg drop minimum trials unit: two row memories with one shared
// add, max and min datapath under a small sequencer.
// Depends on edmt_pkg for payload widths and the state type.
//
// A request transaction on req_ gives eggs and floors. Exactly one response
// transaction on rsp_ returns the worst-case minimum number of drops in
// rsp_trials. Zero eggs answers 0 with rsp_bad_request set.
// Eggs above EGGS_MAX and floors above FLOORS_MAX are clamped.
// Let F be the clamped floor count. The first egg row writes floors 0..F
// directly. Each further egg row writes floors 0 and 1 directly and, for each
// floor f from 2 to F, tries every drop floor in turn through the single
// shared compare datapath fed by one registered read port on each row memory,
// then writes the minimum.
// req_stall stays high from acceptance until the result has moved into the
// response register. While rsp_stall holds the response, a new request is
// accepted and computed, and it waits for the register to free up.
// Synchronous reset returns the sequencer to idle with no response pending.
// The row memories are not cleared: each request writes every entry it reads.
module egg_drop_min_trials_unit #(
   parameter int EGGS_MAX   = 16,
   parameter int FLOORS_MAX = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [edmt_pkg::EGGS_W-1:0]   req_eggs,
   input  logic [edmt_pkg::FLOORS_W-1:0] req_floors,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [edmt_pkg::TRIALS_W-1:0] rsp_trials,
   output logic                          rsp_bad_request
);
   import edmt_pkg::*;

   localparam int AW    = $clog2(FLOORS_MAX + 1);
   localparam int CW    = AW + 1;
   localparam int EW    = $clog2(EGGS_MAX + 1);
   localparam int DEPTH = FLOORS_MAX + 1;

   state_type state_ff, state_in;
   logic [EW-1:0] e_ff, e_in, eggs_ff, eggs_in;
   logic [AW-1:0] f_ff, f_in, x_ff, x_in, floors_ff, floors_in;
   logic [CW-1:0] best_ff, best_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [AW-1:0] res_ff, res_in;
   logic          bad_ff, bad_in;
   logic          rsp_valid_ff;
   logic [TRIALS_W-1:0] rsp_trials_ff;
   logic          rsp_bad_ff;

   logic [AW-1:0] bank0 [DEPTH];
   logic [AW-1:0] bank1 [DEPTH];
   logic [AW-1:0] q0_ff, q1_ff;

   logic          cur_b1, trivial, rd_issue, we, out_free, load;
   logic [AW-1:0] wdata, addr_cur, addr_prev, raddr0, raddr1, cur_q, prev_q;
   logic [CW-1:0] cand, best_min;

   assign cur_b1    = e_ff[0];
   assign addr_cur  = f_ff - x_ff;
   assign addr_prev = x_ff - AW'(1);
   assign raddr0    = cur_b1 ? addr_prev : addr_cur;
   assign raddr1    = cur_b1 ? addr_cur : addr_prev;
   assign cur_q     = cur_b1 ? q1_ff : q0_ff;
   assign prev_q    = cur_b1 ? q0_ff : q1_ff;
   assign cand      = CW'(1) + ((prev_q > cur_q) ? CW'(prev_q) : CW'(cur_q));
   assign best_min  = (cand < best_ff) ? cand : best_ff;
   assign trivial   = (e_ff == EW'(1)) || (f_ff <= AW'(1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = (state_ff == ST_DONE) && out_free;

   always_ff @(posedge clock) begin
      if (we && !cur_b1) begin
         bank0[f_ff] <= wdata;
      end
      if (rd_issue) begin
         q0_ff <= bank0[raddr0];
      end
   end

   always_ff @(posedge clock) begin
      if (we && cur_b1) begin
         bank1[f_ff] <= wdata;
      end
      if (rd_issue) begin
         q1_ff <= bank1[raddr1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      e_ff      <= e_in;
      f_ff      <= f_in;
      x_ff      <= x_in;
      eggs_ff   <= eggs_in;
      floors_ff <= floors_in;
      best_ff   <= best_in;
      res_ff    <= res_in;
      bad_ff    <= bad_in;
   end

   always_comb begin
      state_in  = state_ff;
      e_in      = e_ff;
      f_in      = f_ff;
      x_in      = x_ff;
      eggs_in   = eggs_ff;
      floors_in = floors_ff;
      best_in   = best_ff;
      res_in    = res_ff;
      bad_in    = bad_ff;
      we        = 1'b0;
      wdata     = '0;
      rd_issue  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               eggs_in   = (int'(req_eggs) > EGGS_MAX) ? EW'(EGGS_MAX) : EW'(req_eggs);
               floors_in = (int'(req_floors) > FLOORS_MAX) ? AW'(FLOORS_MAX)
                                                            : AW'(req_floors);
               e_in      = EW'(1);
               f_in      = '0;
               x_in      = AW'(1);
               best_in   = '1;
               if (req_eggs == '0) begin
                  res_in   = '0;
                  bad_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  bad_in   = 1'b0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (trivial) begin
               we    = 1'b1;
               wdata = f_ff;
            end else begin
               rd_issue = 1'b1;
               if (rd_valid_ff) begin
                  best_in = best_min;
               end
               if (x_ff == f_ff) begin
                  state_in = ST_LAST;
               end else begin
                  x_in = x_ff + AW'(1);
               end
            end
         end
         ST_LAST: begin
            we      = 1'b1;
            wdata   = AW'(best_min);
            best_in = '1;
            x_in    = AW'(1);
            state_in = ST_ISSUE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (we) begin
         if (f_ff == floors_ff) begin
            f_in = '0;
            e_in = e_ff + EW'(1);
            if (e_ff == eggs_ff) begin
               res_in   = wdata;
               state_in = ST_DONE;
            end
         end else begin
            f_in = f_ff + AW'(1);
         end
      end
      rd_valid_in = rd_issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_trials_ff <= TRIALS_W'(res_ff);
         rsp_bad_ff    <= bad_ff;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_trials      = rsp_trials_ff;
   assign rsp_bad_request = rsp_bad_ff;

endmodule

[test/testbench.sv]
// Self-checking testbench for the egg drop minimum trials unit.
// Depends on edmt_pkg and egg_drop_min_trials_unit; predicts every response
// with its own two-row dynamic program and compares transactions in order.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import edmt_pkg::*;

   localparam int EGGS_LIMIT    = 16;
   localparam int FLOORS_LIMIT  = 1024;
   localparam int TRIALS_CAP    = 2047;
   localparam int RANDOM_ITEMS  = 100;
   localparam int QUIET_TAIL    = 20;
   localparam int LONG_HOLD     = 20000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 10;
   localparam longint CYCLE_LIMIT = 6_000_000;

   typedef struct packed {
      logic [EGGS_W-1:0]   eggs;
      logic [FLOORS_W-1:0] floors;
   } drop_request_type;

   typedef struct packed {
      logic [TRIALS_W-1:0] trials;
      logic                bad_request;
   } drop_answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [EGGS_W-1:0]   req_eggs = '0;
   logic [FLOORS_W-1:0] req_floors = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TRIALS_W-1:0] rsp_trials;
   logic                rsp_bad_request;

   drop_request_type request_queue[$];
   drop_answer_type  pending_answers[$];

   logic req_taken = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;
   int   pressure_at = 1 << 30;
   int   accepted_count = 0;
   int   checked_count = 0;
   int   zero_egg_count = 0;
   int   fail_count = 0;
   longint cycle_count = 0;

   egg_drop_min_trials_unit #(
      .EGGS_MAX   (EGGS_LIMIT),
      .FLOORS_MAX (FLOORS_LIMIT)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_eggs        (req_eggs),
      .req_floors      (req_floors),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_trials      (rsp_trials),
      .rsp_bad_request (rsp_bad_request)
   );

   always #1 clock = ~clock;

   function automatic drop_answer_type worst_case_drops(input drop_request_type item);
      int unsigned fewer_row [0:FLOORS_LIMIT];
      int unsigned build_row [0:FLOORS_LIMIT];
      int unsigned n_eggs;
      int unsigned n_floors;
      int unsigned best;
      int unsigned cand;
      int unsigned worse;
      drop_answer_type answer;
      answer.bad_request = 1'b0;
      answer.trials = '0;
      if (item.eggs == '0) begin
         answer.bad_request = 1'b1;
         return answer;
      end
      n_eggs = (item.eggs > EGGS_LIMIT) ? EGGS_LIMIT : item.eggs;
      n_floors = (item.floors > FLOORS_LIMIT) ? FLOORS_LIMIT : item.floors;
      for (int f = 0; f <= n_floors; f++) build_row[f] = f;
      for (int e = 2; e <= n_eggs; e++) begin
         fewer_row = build_row;
         build_row[0] = 0;
         if (n_floors >= 1) build_row[1] = 1;
         for (int f = 2; f <= n_floors; f++) begin
            worse = (fewer_row[0] > build_row[f-1]) ? fewer_row[0] : build_row[f-1];
            best = 1 + worse;
            for (int x = 2; x <= f; x++) begin
               worse = (fewer_row[x-1] > build_row[f-x]) ? fewer_row[x-1] : build_row[f-x];
               cand = 1 + worse;
               if (cand < best) best = cand;
            end
            build_row[f] = best & 16'hFFFF;
         end
      end
      best = build_row[n_floors];
      if (best > TRIALS_CAP) best = TRIALS_CAP;
      answer.trials = best[TRIALS_W-1:0];
      return answer;
   endfunction

   task automatic queue_request(input int eggs, input int floors);
      drop_request_type item;
      item.eggs = eggs[EGGS_W-1:0];
      item.floors = floors[FLOORS_W-1:0];
      request_queue.push_back(item);
   endtask

   // Request driver: a new transaction is offered only after the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (request_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (request_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 16);
         end else begin
            req_valid <= 1'b1;
            req_eggs <= request_queue[0].eggs;
            req_floors <= request_queue[0].floors;
            request_queue.pop_front();
         end
      end
   end

   // Response stall generator, including one long hold-off to back the block up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count >= pressure_at) begin
         rsp_stall <= 1'b1;
         hold_done <= 1'b1;
         hold_left <= LONG_HOLD;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (request_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: checks the response side first, then records any accepted request.
   always @(posedge clock) begin
      drop_answer_type expected;
      cycle_count++;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected response: trials %0d bad_request %0b",
                        rsp_trials, rsp_bad_request);
         end else begin
            expected = pending_answers.pop_front();
            checked_count++;
            if (rsp_trials !== expected.trials || rsp_bad_request !== expected.bad_request) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"mismatch: expected trials %0d bad_request %0b,",
                            " got trials %0d bad_request %0b"},
                           expected.trials, expected.bad_request, rsp_trials,
                           rsp_bad_request);
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         drop_request_type item;
         item.eggs = req_eggs;
         item.floors = req_floors;
         pending_answers.push_back(worst_case_drops(item));
         accepted_count++;
         if (req_eggs == '0) zero_egg_count++;
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int sel;
      int eggs;
      int floors;

      queue_request(0, 0);
      queue_request(0, 2047);
      queue_request(1, 0);
      queue_request(1, 1);
      queue_request(1, 1023);
      queue_request(1, 1024);
      queue_request(1, 2047);
      queue_request(2, 0);
      queue_request(2, 1);
      queue_request(2, 2);
      queue_request(2, 10);
      queue_request(2, 100);
      queue_request(2, 1024);
      queue_request(3, 120);
      queue_request(16, 0);
      queue_request(16, 1);
      queue_request(16, 7);
      queue_request(16, 100);
      queue_request(17, 2);
      queue_request(31, 0);
      queue_request(31, 1);
      queue_request(31, 60);
      pressure_at = request_queue.size() + 10;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(0, 19);
         if (sel < 14) begin
            eggs = $urandom_range(1, EGGS_LIMIT);
            floors = (eggs == 1) ? $urandom_range(0, 2047) : $urandom_range(0, 32);
         end else if (sel < 16) begin
            eggs = 0;
            floors = $urandom_range(0, 2047);
         end else if (sel < 18) begin
            eggs = 1;
            floors = $urandom_range(0, 2047);
         end else begin
            eggs = $urandom_range(EGGS_LIMIT + 1, 31);
            floors = $urandom_range(0, 24);
         end
         queue_request(eggs, floors);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d responses for %0d requests, %0d of them with zero eggs,",
               checked_count, accepted_count, zero_egg_count);
      $display("covering clamped eggs and floors up to the full floor limit.");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures", fail_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
